// ===== hw/rtl/cone_density_sensitivity_filter_top_defines.svh =====
// Assertion helpers shared by the filter RTL.
// Each macro expects clk and rst_n in scope.
`ifndef CONE_DENSITY_SENSITIVITY_FILTER_TOP_DEFINES_SVH
`define CONE_DENSITY_SENSITIVITY_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CDSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CDSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cdsf_pkg.sv =====
package cdsf_pkg;

  // Field widths
  localparam int COORD_W     = 6;
  localparam int SENS_W      = 32;
  localparam int GRID_W      = 7;
  localparam int RAD_W       = 12;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 64;
  localparam int DIVIDEND_W  = SENS_W + 8;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRID_WIDTH    = 2'd0,
    REG_GRID_HEIGHT   = 2'd1,
    REG_FILTER_RADIUS = 2'd2
  } cfg_reg_t;

  // Item kinds and result status
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_QUERY   = 1'b1;
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_OUTSIDE = 1'b1;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Integer square root; used on constants only, folded at elaboration
  function automatic logic [15:0] isqrt_f(input logic [31:0] v);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] bitv;
    rem  = v;
    root = '0;
    bitv = 32'h4000_0000;
    for (int k = 0; k < 16; k++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[15:0];
  endfunction

endpackage

// ===== hw/rtl/cdsf_ram.sv =====
module cdsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/cdsf_div.sv =====
module cdsf_div #(
  parameter int NW = 40,
  parameter int DW = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NW-1:0]       dividend,
  input  logic [DW-1:0]       divisor,
  output logic [31:0]         quot,
  output cdsf_pkg::div_stat_t st
);
  import cdsf_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic          neg_r;
  logic [31:0]   quot_r;

  logic [DW:0]   rem_sh;
  logic          qbit;
  logic [NW:0]   sq;
  logic          fits;

  // One quotient bit per cycle, restoring
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign qbit   = rem_sh >= {1'b0, dvs_r};

  // Apply sign and saturate to 32 bits
  assign sq   = neg_r ? (NW+1)'(-{1'b0, quo_r}) : {1'b0, quo_r};
  assign fits = (&sq[NW:31]) | ~(|sq[NW:31]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        num_r  <= dividend[NW-1] ? NW'(-dividend) : dividend;
        quo_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
        neg_r  <= dividend[NW-1];
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          rem_r <= qbit ? DW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DW-1:0];
          quo_r <= {quo_r[NW-2:0], qbit};
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (dvs_r == '0) begin
            quot_r <= '0;
          end else if (fits) begin
            quot_r <= sq[31:0];
          end else begin
            quot_r <= sq[NW] ? 32'h8000_0000 : 32'h7fff_ffff;
          end
        end
      end
    end
  end

  assign quot    = quot_r;
  assign st.busy = busy_r;
  assign st.done = done_r;

endmodule

// ===== hw/rtl/cone_density_sensitivity_filter_top.sv =====
// Cone-kernel filter for two sensitivity fields on an element grid. A load beat
// (tuser 0) walks the element's clipped window to sum its cone weights, divides
// both raw sensitivities by that sum and writes the quotients into two
// single-port-write RAMs, the division being one quotient bit a cycle. A query
// beat (tuser 1) reads one window element a cycle from both RAMs and
// accumulates weight * quotient over a window of up to 15 by 15 elements. One
// item is worked at a time; a finished result waits in the output register
// while the next item is taken. Queries outside the grid return status 1 and
// zero data; loads outside the grid are dropped. Query only elements that were
// loaded.
module cone_density_sensitivity_filter_top #(
  parameter int MAX_GRID_X      = 64,
  parameter int MAX_GRID_Y      = 64,
  parameter int MAX_WINDOW_HALF = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // element_x[5:0], element_y[11:6], compliance_sens[43:12], volume_sens[75:44]
  input  logic [cdsf_pkg::IN_TDATA_W-1:0]      in_tdata,
  // mode[0]
  input  logic [0:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // filtered_compliance[31:0], filtered_volume[63:32]
  output logic [cdsf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // status[0]
  output logic [0:0]                           out_tuser,
  input  logic                                 cfg_we,
  input  logic [cdsf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [cdsf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import cdsf_pkg::*;
  `include "cone_density_sensitivity_filter_top_defines.svh"

  localparam int MWH   = MAX_WINDOW_HALF;
  localparam int DEPTH = MAX_GRID_X * MAX_GRID_Y;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int TD    = MWH * MWH;
  localparam int TW    = TD > 1 ? $clog2(TD) : 1;
  localparam int WSPAN = (2 * MWH - 1) * (2 * MWH - 1);
  localparam int SW    = $clog2(WSPAN * 4096);
  localparam int PW    = SENS_W + RAD_W + 1;
  localparam int ACW   = PW + $clog2(WSPAN + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_WAIT, ST_RES} state_t;

  state_t state_r;

  // Configuration registers
  logic [GRID_W-1:0] gw_r;
  logic [GRID_W-1:0] gh_r;
  logic [RAD_W-1:0]  rad_r;

  // Item registers
  logic                     mode_r;
  logic [COORD_W-1:0]       cx_r;
  logic [COORD_W-1:0]       cy_r;
  logic signed [SENS_W-1:0] sc_r;
  logic signed [SENS_W-1:0] sv_r;

  // Window walk
  logic       scan_act_r;
  logic [6:0] i_r, j_r, x0_r, y0_r, x1m_r, y1m_r;

  // Read pipeline
  logic                  s1_vld_r;
  logic [RAD_W-1:0]      s1_wt_r;
  logic                  s2_vld_r;
  logic [RAD_W-1:0]      s2_wt_r;
  logic signed [PW-1:0]  s2_pc_r;
  logic signed [PW-1:0]  s2_pv_r;
  logic signed [ACW-1:0] acc_c_r;
  logic signed [ACW-1:0] acc_v_r;
  logic [SW-1:0]         sum_r;

  // Output register
  logic                out_tvalid_r;
  logic [SENS_W-1:0]   out_c_r;
  logic [SENS_W-1:0]   out_v_r;
  logic                out_st_r;
  logic [SENS_W-1:0]   res_c_r;
  logic [SENS_W-1:0]   res_v_r;
  logic                res_st_r;

  // Constant distance table, Q8.8
  logic [15:0] dist_tab [TD];

  for (genvar gx = 0; gx < MWH; gx++) begin : g_dx
    for (genvar gy = 0; gy < MWH; gy++) begin : g_dy
      assign dist_tab[gx * MWH + gy] = isqrt_f(32'((gx * gx + gy * gy) << 16));
    end
  end

  // Window half-width from the radius
  logic [4:0]  ceil_r;
  logic [4:0]  hwf;
  logic [4:0]  hw;
  assign ceil_r = 5'((13'(rad_r) + 13'd255) >> 8);
  assign hwf    = (ceil_r == '0) ? 5'd0 : ceil_r - 5'd1;
  assign hw     = (32'(hwf) > MWH - 1) ? 5'(MWH - 1) : hwf;

  // Effective grid size and bounds of the incoming item
  logic [10:0]        effw, effh;
  logic [COORD_W-1:0] ax, ay;
  logic               in_grid;
  logic [10:0]        x1e, y1e, x1, y1;
  assign effw    = (32'(gw_r) < MAX_GRID_X) ? 11'(gw_r) : 11'(MAX_GRID_X);
  assign effh    = (32'(gh_r) < MAX_GRID_Y) ? 11'(gh_r) : 11'(MAX_GRID_Y);
  assign ax      = in_tdata[5:0];
  assign ay      = in_tdata[11:6];
  assign in_grid = (11'(ax) < effw) && (11'(ay) < effh);
  assign x1e     = 11'(ax) + 11'(hw) + 11'd1;
  assign y1e     = 11'(ay) + 11'(hw) + 11'd1;
  assign x1      = (x1e < effw) ? x1e : effw;
  assign y1      = (y1e < effh) ? y1e : effh;

  // Weight at the current window position
  logic [6:0]       dx0, dy0;
  logic [TW-1:0]    tidx;
  logic [15:0]      dist0;
  logic [RAD_W-1:0] wt0;
  assign dx0   = (i_r >= 7'(cx_r)) ? i_r - 7'(cx_r) : 7'(cx_r) - i_r;
  assign dy0   = (j_r >= 7'(cy_r)) ? j_r - 7'(cy_r) : 7'(cy_r) - j_r;
  assign tidx  = TW'(int'(dx0) * MWH + int'(dy0));
  assign dist0 = dist_tab[tidx];
  assign wt0   = (16'(rad_r) > dist0) ? RAD_W'(16'(rad_r) - dist0) : '0;

  // Store access
  logic              ram_re;
  logic              ram_we;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [SENS_W-1:0] c_rdata, v_rdata;
  logic [SENS_W-1:0] c_quot, v_quot;
  div_stat_t         c_st, v_st;
  logic              div_go;

  assign ram_re  = scan_act_r && (mode_r == MODE_QUERY);
  assign rd_addr = AW'(int'(j_r) * MAX_GRID_X + int'(i_r));
  assign wr_addr = AW'(int'(cy_r) * MAX_GRID_X + int'(cx_r));
  assign ram_we  = (state_r == ST_WAIT) && c_st.done;
  assign div_go  = (state_r == ST_DIV);

  cdsf_ram #(.WIDTH(SENS_W), .DEPTH(DEPTH)) u_c_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(c_quot),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(c_rdata)
  );

  cdsf_ram #(.WIDTH(SENS_W), .DEPTH(DEPTH)) u_v_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(v_quot),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(v_rdata)
  );

  cdsf_div #(.NW(DIVIDEND_W), .DW(SW)) u_c_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_go),
    .dividend({sc_r, 8'h00}),
    .divisor (sum_r),
    .quot    (c_quot),
    .st      (c_st)
  );

  cdsf_div #(.NW(DIVIDEND_W), .DW(SW)) u_v_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_go),
    .dividend({sv_r, 8'h00}),
    .divisor (sum_r),
    .quot    (v_quot),
    .st      (v_st)
  );

  // Floor to Q16.16 and saturate the window sums
  logic signed [ACW-1:0] sh_c, sh_v;
  logic [SENS_W-1:0]     qc_nxt, qv_nxt;
  assign sh_c   = acc_c_r >>> 8;
  assign sh_v   = acc_v_r >>> 8;
  assign qc_nxt = ((&sh_c[ACW-1:31]) | ~(|sh_c[ACW-1:31])) ? sh_c[31:0] :
                  (sh_c[ACW-1] ? 32'h8000_0000 : 32'h7fff_ffff);
  assign qv_nxt = ((&sh_v[ACW-1:31]) | ~(|sh_v[ACW-1:31])) ? sh_v[31:0] :
                  (sh_v[ACW-1] ? 32'h8000_0000 : 32'h7fff_ffff);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r  <= 7'd64;
      gh_r  <= 7'd64;
      rad_r <= 12'd384;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_WIDTH:    gw_r  <= cfg_wdata[GRID_W-1:0];
        REG_GRID_HEIGHT:   gh_r  <= cfg_wdata[GRID_W-1:0];
        REG_FILTER_RADIUS: rad_r <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read, weigh and accumulate pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= scan_act_r;
      s2_vld_r <= s1_vld_r;
    end
    s1_wt_r <= wt0;
    s2_wt_r <= s1_wt_r;
    s2_pc_r <= PW'($signed(c_rdata) * $signed({1'b0, s1_wt_r}));
    s2_pv_r <= PW'($signed(v_rdata) * $signed({1'b0, s1_wt_r}));
    if (state_r == ST_IDLE) begin
      acc_c_r <= '0;
      acc_v_r <= '0;
      sum_r   <= '0;
    end else if (s2_vld_r) begin
      acc_c_r <= acc_c_r + ACW'(s2_pc_r);
      acc_v_r <= acc_v_r + ACW'(s2_pv_r);
      sum_r   <= sum_r + SW'(s2_wt_r);
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_act_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_tvalid_r && out_tready && state_r != ST_RES) begin
        out_tvalid_r <= 1'b0;
      end

      // advance the window walk
      if (scan_act_r) begin
        if (i_r == x1m_r) begin
          i_r <= x0_r;
          if (j_r == y1m_r) begin
            scan_act_r <= 1'b0;
          end else begin
            j_r <= j_r + 7'd1;
          end
        end else begin
          i_r <= i_r + 7'd1;
        end
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            mode_r <= in_tuser[0];
            cx_r   <= ax;
            cy_r   <= ay;
            sc_r   <= in_tdata[43:12];
            sv_r   <= in_tdata[75:44];
            x0_r   <= (7'(ax) > 7'(hw)) ? 7'(ax) - 7'(hw) : 7'd0;
            y0_r   <= (7'(ay) > 7'(hw)) ? 7'(ay) - 7'(hw) : 7'd0;
            i_r    <= (7'(ax) > 7'(hw)) ? 7'(ax) - 7'(hw) : 7'd0;
            j_r    <= (7'(ay) > 7'(hw)) ? 7'(ay) - 7'(hw) : 7'd0;
            x1m_r  <= 7'(x1 - 11'd1);
            y1m_r  <= 7'(y1 - 11'd1);
            if (in_grid) begin
              scan_act_r <= 1'b1;
              state_r    <= ST_SCAN;
            end else if (in_tuser[0] == MODE_QUERY) begin
              res_c_r  <= '0;
              res_v_r  <= '0;
              res_st_r <= STAT_OUTSIDE;
              state_r  <= ST_RES;
            end
          end
        end
        ST_SCAN: begin
          if (!scan_act_r && !s1_vld_r && !s2_vld_r) begin
            if (mode_r == MODE_QUERY) begin
              res_c_r  <= qc_nxt;
              res_v_r  <= qv_nxt;
              res_st_r <= STAT_OK;
              state_r  <= ST_RES;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (c_st.done) begin
            state_r <= ST_IDLE;
          end
        end
        ST_RES: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_c_r      <= res_c_r;
            out_v_r      <= res_v_r;
            out_st_r     <= res_st_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_v_r, out_c_r};
  assign out_tuser  = out_st_r;

  // Checks
  logic st_res, st_wait;
  assign st_res  = (state_r == ST_RES);
  assign st_wait = (state_r == ST_WAIT);

  `CDSF_ASSERT_NOW(a_we_no_scan, ram_we, !scan_act_r && !s1_vld_r && !s2_vld_r, "store write during window walk")
  `CDSF_ASSERT_NOW(a_div_lockstep, c_st.done || v_st.done, c_st.done && v_st.done, "dividers out of step")
  `CDSF_ASSERT_NOW(a_wait_div, st_wait, c_st.busy || c_st.done, "waiting on an idle divider")
  `CDSF_ASSERT_NEXT(a_res_src, $rose(out_tvalid_r) == 1'b0, 1'b1, "unused")
  `CDSF_ASSERT_NOW(a_res_from_state, $rose(out_tvalid_r), $past(st_res), "result without finished query")
  `CDSF_ASSERT_NOW(a_pipe_order, s2_vld_r, $past(s1_vld_r), "accumulate stage without read")

endmodule
